### rtl/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg: shared types and constants of the 3x3 matrix inverse unit
// Entry, product, cofactor and determinant widths, plus the side-band
// tag that travels through the divider pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  // Matrix entry and result width, and number of entries.
  localparam int EW = 32;
  localparam int NE = 9;
  // Product of two entries, cofactor and determinant widths.
  localparam int PW = 64;
  localparam int CW = 65;
  localparam int DW = 97;
  // Magnitude of the determinant, and number of quotient bits.
  localparam int MW = 96;
  localparam int QW = 32;

  typedef logic signed [EW-1:0] ent_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [DW-1:0] det_t;
  typedef logic [MW-1:0]        mag_t;
  typedef logic [PW-1:0]        cmag_t;
  typedef logic [QW-1:0]        quo_t;

  // Side-band of one word inside the divider.
  typedef struct packed {
    logic          zero;
    logic [NE-1:0] neg;
    logic [NE-1:0] big;
  } tag_t;

  // Saturation limits of a signed result with 32 fraction bits (Q0.32).
  localparam quo_t SAT_POS = 32'h7FFF_FFFF;
  localparam quo_t SAT_NEG = 32'h8000_0000;

endpackage

### rtl/matrix3x3_inverse_unit.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit: 3x3 matrix inverse by the adjugate
// Exact cofactors and determinant, then nine pipelined divisions giving the
// inverse as signed fixed point with 32 fraction bits (Q0.32), truncated toward zero and saturated.
// ----------------------------------------------------------------------------
//  Channel  Ports                   Word contents (lowest bits first)
//  input    in_tvalid/tready/tdata  a11 a12 a13 a21 a22 a23 a31 a32 a33, 32 each
//  output   out_tvalid/tready/tdata r11 .. r33, 32 bits each
//           out_tuser               singular, saturated
//
// One word is accepted per cycle while the output is not stalled; each result passes
// through 7 stages of products, cofactors and determinant, 32 divider stages and
// the output register. The 32-stage bit-per-stage divider makes up most of the pipeline.
// Reset clears the valid bits only. A stall on the output holds every stage
// in place, so nothing is lost or repeated.
module matrix3x3_inverse_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // a11, a12, a13, a21, a22, a23, a31, a32, a33
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // r11, r12, r13, r21, r22, r23, r31, r32, r33
  output logic [1:0]   out_tuser   // singular, saturated
);

  localparam int NE = m3inv_pkg::NE;
  localparam int EW = m3inv_pkg::EW;

  // Cofactor operand indices: adj[k] = e[P]*e[R] - e[Q]*e[S].
  localparam int COF_P [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int COF_R [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int COF_Q [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int COF_S [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic en;
  logic [6:0] vld_r;

  m3inv_pkg::ent_t  ent [NE];
  m3inv_pkg::prod_t pp_r [NE];
  m3inv_pkg::prod_t pq_r [NE];
  m3inv_pkg::ent_t  a1_r [3];
  m3inv_pkg::ent_t  a2_r [3];
  m3inv_pkg::cof_t  cof2_r [NE];
  m3inv_pkg::cof_t  cof3_r [NE];
  m3inv_pkg::cof_t  cof4_r [NE];
  m3inv_pkg::cof_t  cof5_r [NE];
  logic signed [m3inv_pkg::CW-1:0] plo_r [3];
  logic signed [m3inv_pkg::CW-1:0] phi_r [3];
  m3inv_pkg::det_t  term_r [3];
  m3inv_pkg::det_t  det_r;
  m3inv_pkg::mag_t  den6_r;
  logic             zero6_r;
  logic [NE-1:0]    neg6_r;
  m3inv_pkg::cmag_t cm6_r [NE];
  m3inv_pkg::mag_t  den7_r;
  m3inv_pkg::cmag_t cm7_r [NE];
  m3inv_pkg::tag_t  tag7_r;

  logic             dv_vld;
  m3inv_pkg::tag_t  dv_tag;
  m3inv_pkg::quo_t  dv_q [NE];

  logic             out_vld_r;
  logic [287:0]     out_data_r;
  logic [1:0]       out_user_r;
  logic [287:0]     out_data_nxt;
  logic [1:0]       out_user_nxt;

  // The whole pipe moves while the output register is free or being read.
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      ent[k] = in_tdata[k*EW +: EW];
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_tvalid};
    end
  end

  // Front stages: products, cofactors, determinant, magnitudes.
  always_ff @(posedge clk) begin
    m3inv_pkg::det_t dabs;
    m3inv_pkg::cof_t cabs;
    if (en) begin
      // Products of entry pairs.
      for (int k = 0; k < NE; k++) begin
        pp_r[k] <= ent[COF_P[k]] * ent[COF_R[k]];
        pq_r[k] <= ent[COF_Q[k]] * ent[COF_S[k]];
      end
      for (int j = 0; j < 3; j++) begin
        a1_r[j] <= ent[j];
        a2_r[j] <= a1_r[j];
      end
      // Exact cofactors.
      for (int k = 0; k < NE; k++) begin
        cof2_r[k] <= m3inv_pkg::cof_t'(pp_r[k]) - m3inv_pkg::cof_t'(pq_r[k]);
        cof3_r[k] <= cof2_r[k];
        cof4_r[k] <= cof3_r[k];
        cof5_r[k] <= cof4_r[k];
      end
      // Top-row expansion, split into two partial products per term.
      for (int j = 0; j < 3; j++) begin
        plo_r[j] <= $signed({1'b0, cof2_r[3*j][EW-1:0]}) * a2_r[j];
        phi_r[j] <= $signed(cof2_r[3*j][m3inv_pkg::CW-1:EW]) * a2_r[j];
      end
      for (int j = 0; j < 3; j++) begin
        term_r[j] <= (m3inv_pkg::det_t'(phi_r[j]) <<< EW) + m3inv_pkg::det_t'(plo_r[j]);
      end
      det_r <= term_r[0] + term_r[1] + term_r[2];
      // Magnitudes and signs.
      dabs    = det_r[m3inv_pkg::DW-1] ? -det_r : det_r;
      den6_r  <= dabs[m3inv_pkg::MW-1:0];
      zero6_r <= (det_r == '0);
      for (int k = 0; k < NE; k++) begin
        cabs      = cof5_r[k][m3inv_pkg::CW-1] ? -cof5_r[k] : cof5_r[k];
        cm6_r[k]  <= cabs[m3inv_pkg::PW-1:0];
        neg6_r[k] <= cof5_r[k][m3inv_pkg::CW-1] ^ det_r[m3inv_pkg::DW-1];
      end
      // A quotient of 2^32 or more is flagged here and clamped at the end.
      den7_r      <= den6_r;
      tag7_r.zero <= zero6_r;
      tag7_r.neg  <= neg6_r;
      for (int k = 0; k < NE; k++) begin
        cm7_r[k]      <= cm6_r[k];
        tag7_r.big[k] <= ({{(m3inv_pkg::MW - m3inv_pkg::PW){1'b0}}, cm6_r[k]} >= den6_r);
      end
    end
  end

  m3inv_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vld_r[6]),
    .tag_i (tag7_r),
    .den_i (den7_r),
    .cm_i  (cm7_r),
    .vld_o (dv_vld),
    .tag_o (dv_tag),
    .q_o   (dv_q)
  );

  // Saturation, sign and the singular case.
  always_comb begin
    logic            ov;
    logic            sat;
    m3inv_pkg::quo_t v;
    ov  = 1'b0;
    sat = 1'b0;
    v   = '0;
    out_data_nxt = '0;
    for (int k = 0; k < NE; k++) begin
      if (dv_tag.neg[k]) begin
        ov = dv_tag.big[k] || (dv_q[k][EW-1] && (|dv_q[k][EW-2:0]));
        v  = ov ? m3inv_pkg::SAT_NEG : dv_q[k];
        v  = -v;
      end else begin
        ov = dv_tag.big[k] || dv_q[k][EW-1];
        v  = ov ? m3inv_pkg::SAT_POS : dv_q[k];
      end
      sat = sat | ov;
      out_data_nxt[k*EW +: EW] = v;
    end
    if (dv_tag.zero) begin
      out_data_nxt = '0;
      out_user_nxt = 2'b01;
    end else begin
      out_user_nxt = {sat, 1'b0};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### rtl/m3inv_divider.sv
// ----------------------------------------------------------------------------
// m3inv_divider: nine-lane pipelined restoring divider
// Each lane divides a cofactor magnitude, shifted up by 32 bits, by the shared
// determinant magnitude, one quotient bit per stage over 32 stages.
// ----------------------------------------------------------------------------
module m3inv_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  m3inv_pkg::tag_t        tag_i,
  input  m3inv_pkg::mag_t        den_i,
  input  m3inv_pkg::cmag_t       cm_i [m3inv_pkg::NE],
  output logic                   vld_o,
  output m3inv_pkg::tag_t        tag_o,
  output m3inv_pkg::quo_t        q_o [m3inv_pkg::NE]
);

  localparam int NS = m3inv_pkg::QW;

  logic [NS-1:0]     vld_r;
  m3inv_pkg::tag_t   tag_r [NS];
  m3inv_pkg::mag_t   den_r [NS];
  m3inv_pkg::mag_t   rem_r [NS][m3inv_pkg::NE];
  m3inv_pkg::quo_t   q_r   [NS][m3inv_pkg::NE];

  m3inv_pkg::mag_t   rem_src [NS][m3inv_pkg::NE];
  m3inv_pkg::quo_t   q_src   [NS][m3inv_pkg::NE];
  m3inv_pkg::mag_t   den_src [NS];
  m3inv_pkg::mag_t   rem_nxt [NS][m3inv_pkg::NE];
  m3inv_pkg::quo_t   q_nxt   [NS][m3inv_pkg::NE];

  // Stage inputs: the first stage takes the ports, the others the stage before.
  always_comb begin
    for (int k = 0; k < m3inv_pkg::NE; k++) begin
      rem_src[0][k] = {{(m3inv_pkg::MW - m3inv_pkg::PW){1'b0}}, cm_i[k]};
      q_src[0][k]   = '0;
    end
    den_src[0] = den_i;
    for (int s = 1; s < NS; s++) begin
      for (int k = 0; k < m3inv_pkg::NE; k++) begin
        rem_src[s][k] = rem_r[s-1][k];
        q_src[s][k]   = q_r[s-1][k];
      end
      den_src[s] = den_r[s-1];
    end
  end

  // One restoring step per stage and lane: shift, compare, subtract.
  always_comb begin
    logic [m3inv_pkg::MW:0] sh;
    logic                   ge;
    sh = '0;
    ge = 1'b0;
    for (int s = 0; s < NS; s++) begin
      for (int k = 0; k < m3inv_pkg::NE; k++) begin
        sh = {rem_src[s][k], 1'b0};
        ge = (sh >= {1'b0, den_src[s]});
        // The difference is below the divisor, so its low bits are exact.
        if (ge) begin
          rem_nxt[s][k] = sh[m3inv_pkg::MW-1:0] - den_src[s];
        end else begin
          rem_nxt[s][k] = sh[m3inv_pkg::MW-1:0];
        end
        q_nxt[s][k] = {q_src[s][k][m3inv_pkg::QW-2:0], ge};
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], vld_i};
    end
  end

  // Data registers of every stage.
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= tag_i;
      for (int s = 1; s < NS; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
      for (int s = 0; s < NS; s++) begin
        den_r[s] <= den_src[s];
        for (int k = 0; k < m3inv_pkg::NE; k++) begin
          rem_r[s][k] <= rem_nxt[s][k];
          q_r[s][k]   <= q_nxt[s][k];
        end
      end
    end
  end

  assign vld_o = vld_r[NS-1];
  assign tag_o = tag_r[NS-1];
  always_comb begin
    for (int k = 0; k < m3inv_pkg::NE; k++) begin
      q_o[k] = q_r[NS-1][k];
    end
  end

endmodule
